>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

>>> hdl/mcoc_pkg.sv
// Package with the shared types and constants of the matrix chain cost block.
package mcoc_pkg;

	localparam int COST_W   = 64;
	localparam int DIM_IN_W = 16;
	localparam int SPLIT_W  = 5;
	localparam int CFG_W    = 6;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_HEAD,
		ST_ISSUE,
		ST_DRAIN,
		ST_WRITE,
		ST_DONE
	} mcoc_state_t;

	// Control from the sequencer to the evaluation pipeline and the result registers.
	typedef struct packed {
		logic head;   // reading the interval's outer dimensions
		logic issue;  // one split candidate issued this cycle
		logic first;  // issued candidate is split offset zero
		logic last;   // issued candidate is the last split offset
		logic wr;     // interval result written to the cost table
		logic clr;    // new chain starts, clear the result
		logic emit;   // result strobe
	} mcoc_ctl_t;

endpackage

>>> hdl/mcoc_ram.sv
// Simple dual-read, single-write memory with registered read data.
module mcoc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> hdl/mcoc_ctrl.sv
// Sequencer: dimension loading, interval and split loops, memory addressing.
module mcoc_ctrl import mcoc_pkg::*; #(
	parameter int MAX_MATRICES = 32,
	localparam int IW    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1,
	localparam int CNT_W = $clog2(MAX_MATRICES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pipe_busy,
	output logic             busy,
	output logic             cfg_ready,
	output mcoc_ctl_t        ctl,
	output logic             dims_we,
	output logic [CNT_W-1:0] dims_waddr,
	output logic [CNT_W-1:0] dims_raddr_a,
	output logic [CNT_W-1:0] dims_raddr_b,
	output logic [2*IW-1:0]  cost_waddr,
	output logic [2*IW-1:0]  cost_raddr_a,
	output logic [2*IW-1:0]  cost_raddr_b
);

	mcoc_state_t      state_q, state_nxt;
	logic [CFG_W-1:0] count_q;
	logic [CNT_W-1:0] load_q;
	logic [CNT_W-1:0] len_q;
	logic [IW-1:0]    lo_q, hi_q, k_q;
	logic [CNT_W-1:0] n_eff;
	logic             accept, last_dim, k_last, row_end;

	// Out-of-range counts are clamped to the supported chain lengths.
	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if ({1'b0, count_q} > (CFG_W + 1)'(MAX_MATRICES)) begin
			n_eff = CNT_W'(MAX_MATRICES);
		end else begin
			n_eff = CNT_W'(count_q);
		end
	end

	assign accept   = start && (state_q == ST_LOAD);
	assign last_dim = (load_q == n_eff);
	assign k_last   = (CNT_W'(k_q) == len_q - CNT_W'(2));
	assign row_end  = (CNT_W'(hi_q) == n_eff - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= CFG_W'(1);
			load_q  <= '0;
			len_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				count_q <= cfg_data;
				load_q  <= '0;
			end else if (accept) begin
				load_q <= last_dim ? '0 : load_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept && last_dim) begin
						len_q <= CNT_W'(2);
						lo_q  <= '0;
						hi_q  <= IW'(1);
						k_q   <= '0;
					end
				end
				ST_HEAD: begin
					k_q <= '0;
				end
				ST_ISSUE: begin
					k_q <= k_q + IW'(1);
				end
				ST_WRITE: begin
					if (row_end) begin
						len_q <= len_q + CNT_W'(1);
						lo_q  <= '0;
						hi_q  <= IW'(len_q);
					end else begin
						lo_q <= lo_q + IW'(1);
						hi_q <= hi_q + IW'(1);
					end
				end
				ST_DRAIN, ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && last_dim) begin
					state_nxt = (n_eff == CNT_W'(1)) ? ST_DONE : ST_HEAD;
				end
			end
			ST_HEAD:  state_nxt = ST_ISSUE;
			ST_ISSUE: begin
				if (k_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_nxt = ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_nxt = (row_end && len_q == n_eff) ? ST_DONE : ST_HEAD;
			end
			ST_DONE:  state_nxt = ST_LOAD;
			default:  state_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		busy       = (state_q != ST_LOAD);
		cfg_ready  = (state_q == ST_LOAD);
		ctl.head   = (state_q == ST_HEAD);
		ctl.issue  = (state_q == ST_ISSUE);
		ctl.first  = (k_q == '0);
		ctl.last   = k_last;
		ctl.wr     = (state_q == ST_WRITE);
		ctl.clr    = accept && last_dim;
		ctl.emit   = (state_q == ST_DONE);
		dims_we    = accept;
		dims_waddr = load_q;
		// The head cycle reads the left dimension, the issue cycles the split dimension.
		dims_raddr_a = (state_q == ST_HEAD) ? CNT_W'(lo_q)
			: CNT_W'(lo_q) + CNT_W'(k_q) + CNT_W'(1);
		dims_raddr_b = CNT_W'(hi_q) + CNT_W'(1);
		cost_waddr   = {lo_q, hi_q};
		cost_raddr_a = {lo_q, IW'(lo_q + k_q)};
		cost_raddr_b = {IW'(lo_q + k_q + IW'(1)), hi_q};
	end

endmodule

>>> hdl/mcoc_eval.sv
// Shared candidate pipeline: dimension product, saturating sums and running minimum.
module mcoc_eval import mcoc_pkg::*; #(
	parameter int DW = 16,
	parameter int IW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mcoc_ctl_t         ctl,
	input  logic [IW-1:0]     k,
	input  logic [DW-1:0]     dim_a,
	input  logic [DW-1:0]     dim_b,
	input  logic [COST_W-1:0] cost_a,
	input  logic [COST_W-1:0] cost_b,
	output logic [COST_W-1:0] best_cost,
	output logic [IW-1:0]     best_k,
	output logic              best_sat,
	output logic              pipe_busy
);

	logic              v_s1, v_s2, v_s3;
	logic              head_s1, first_s1, last_s1, first_s2, first_s3;
	logic [IW-1:0]     k_s1, k_s2, k_s3;
	logic [DW-1:0]     d_lo_q, d_hi_q;
	logic [2*DW-1:0]   prod_s2;
	logic [3*DW-1:0]   prod_s3;
	logic [COST_W-1:0] sum_s2, sum_s3;
	logic              sat_s2, sat_s3;
	logic [COST_W-1:0] part_a, part_b, cand;
	logic [COST_W:0]   sum1, sum2;
	logic              cand_sat;
	logic [COST_W-1:0] best_q;
	logic [IW-1:0]     best_k_q;
	logic              best_sat_q;

	// Diagonal entries are never stored; they count as zero.
	assign part_a = first_s1 ? '0 : cost_a;
	assign part_b = last_s1 ? '0 : cost_b;
	assign sum1   = {1'b0, part_a} + {1'b0, part_b};
	assign sum2   = {1'b0, sum_s3} + {1'b0, COST_W'(prod_s3)};
	assign cand     = sum2[COST_W] ? COST_MAX : sum2[COST_W-1:0];
	assign cand_sat = sat_s3 || sum2[COST_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			head_s1 <= 1'b0;
		end else begin
			v_s1    <= ctl.issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			head_s1 <= ctl.head;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= ctl.first;
		last_s1  <= ctl.last;
		k_s1     <= k;
		if (head_s1) begin
			d_lo_q <= dim_a;
			d_hi_q <= dim_b;
		end
		prod_s2  <= {{DW{1'b0}}, d_lo_q} * {{DW{1'b0}}, dim_a};
		sum_s2   <= sum1[COST_W] ? COST_MAX : sum1[COST_W-1:0];
		sat_s2   <= sum1[COST_W];
		first_s2 <= first_s1;
		k_s2     <= k_s1;
		prod_s3  <= {{DW{1'b0}}, prod_s2} * {{(2*DW){1'b0}}, d_hi_q};
		sum_s3   <= sum_s2;
		sat_s3   <= sat_s2;
		first_s3 <= first_s2;
		k_s3     <= k_s2;
		// The first candidate always loads; later ones replace it only when strictly cheaper.
		if (v_s3 && (first_s3 || cand < best_q)) begin
			best_q     <= cand;
			best_k_q   <= k_s3;
			best_sat_q <= cand_sat;
		end
	end

	assign best_cost = best_q;
	assign best_k    = best_k_q;
	assign best_sat  = best_sat_q;
	assign pipe_busy = v_s1 || v_s2 || v_s3;

endmodule

>>> hdl/matrix_chain_order_cost.sv
// Top level of the matrix chain order cost block.
//
// Channel   Signals                                       Transfer
// input     start, busy, dimension                        start high while busy is low
// config    cfg_valid, cfg_ready, cfg_data                cfg_valid and cfg_ready both high
// result    done, min_cost, top_split, saturated          done high for one cycle
//
// Each dimension is transferred with start while the chain is loading; busy stays low.
// The transfer of the last dimension starts the solve, which holds busy high while
// the single candidate pipeline serves every split of every interval in turn.
// The result strobe follows in the cycle after the last interval is written, and
// busy stays high through that strobe cycle as well.
// Reset clears the sequencer and sets the matrix count to one; the tables hold no reset.
// The receiver cannot stall results, so the block never waits on the output side.
module matrix_chain_order_cost import mcoc_pkg::*; #(
	parameter int MAX_MATRICES = 32,
	parameter int DIM_WIDTH    = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [DIM_IN_W-1:0] dimension,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data,
	output logic                done,
	output logic [COST_W-1:0]   min_cost,
	output logic [SPLIT_W-1:0]  top_split,
	output logic                saturated
);

	localparam int IW    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
	localparam int CNT_W = $clog2(MAX_MATRICES + 1);
	localparam int DW    = (DIM_WIDTH < DIM_IN_W) ? DIM_WIDTH : DIM_IN_W;

	mcoc_ctl_t         ctl;
	logic              cfg_we, pipe_busy, dims_we;
	logic [CNT_W-1:0]  dims_waddr, dims_raddr_a, dims_raddr_b;
	logic [2*IW-1:0]   cost_waddr, cost_raddr_a, cost_raddr_b;
	logic [DW-1:0]     dim_a, dim_b;
	logic [COST_W-1:0] cost_a, cost_b, best_cost;
	logic [IW-1:0]     best_k;
	logic              best_sat;
	logic [COST_W-1:0] min_cost_q;
	logic [SPLIT_W-1:0] top_split_q;
	logic              sat_q;

	assign cfg_we = cfg_valid && cfg_ready;

	// The sequencer walks interval lengths, then left ends, then split offsets.
	mcoc_ctrl #(
		.MAX_MATRICES (MAX_MATRICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.pipe_busy    (pipe_busy),
		.busy         (busy),
		.cfg_ready    (cfg_ready),
		.ctl          (ctl),
		.dims_we      (dims_we),
		.dims_waddr   (dims_waddr),
		.dims_raddr_a (dims_raddr_a),
		.dims_raddr_b (dims_raddr_b),
		.cost_waddr   (cost_waddr),
		.cost_raddr_a (cost_raddr_a),
		.cost_raddr_b (cost_raddr_b)
	);

	// Chain dimensions; only the low bits up to the configured width are kept.
	mcoc_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_MATRICES + 1)
	) u_dims (
		.clk     (clk),
		.we      (dims_we),
		.waddr   (dims_waddr),
		.wdata   (dimension[DW-1:0]),
		.raddr_a (dims_raddr_a),
		.raddr_b (dims_raddr_b),
		.rdata_a (dim_a),
		.rdata_b (dim_b)
	);

	// Interval costs, addressed by left and right matrix index. Only intervals
	// longer than one matrix are stored; each is written before any longer
	// interval reads it.
	mcoc_ram #(
		.WIDTH (COST_W),
		.DEPTH (1 << (2*IW))
	) u_cost (
		.clk     (clk),
		.we      (ctl.wr),
		.waddr   (cost_waddr),
		.wdata   (best_cost),
		.raddr_a (cost_raddr_a),
		.raddr_b (cost_raddr_b),
		.rdata_a (cost_a),
		.rdata_b (cost_b)
	);

	// One candidate split per cycle enters this pipeline while the sequencer issues; the
	// running minimum at its end is the interval's cost once the pipeline has drained.
	mcoc_eval #(
		.DW (DW),
		.IW (IW)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.k         (cost_raddr_a[IW-1:0] - cost_raddr_a[2*IW-1:IW]),
		.dim_a     (dim_a),
		.dim_b     (dim_b),
		.cost_a    (cost_a),
		.cost_b    (cost_b),
		.best_cost (best_cost),
		.best_k    (best_k),
		.best_sat  (best_sat),
		.pipe_busy (pipe_busy)
	);

	// The whole chain is the last interval written, so the result registers
	// simply follow every write. A single-matrix chain keeps the cleared values.
	// The saturation flag gathers over all intervals of the chain.
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			min_cost_q  <= '0;
			top_split_q <= '0;
			sat_q       <= 1'b0;
		end else if (ctl.wr) begin
			min_cost_q  <= best_cost;
			top_split_q <= SPLIT_W'(best_k);
			sat_q       <= sat_q || best_sat;
		end
	end

	assign done      = ctl.emit;
	assign min_cost  = min_cost_q;
	assign top_split = top_split_q;
	assign saturated = sat_q;

endmodule

>>> hdl/mcoc_checker.sv
// Port-level checker for the matrix chain order cost block, with its bind.
`include "assert_macros.svh"

module mcoc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_ready,
	input logic done
);

	// A result only appears while a solve is under way.
	`ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)
	// The result strobe is never asserted twice in a row.
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	// After the result the block is ready for the next chain.
	`ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy)
	// A solve starts only from an accepted dimension.
	`ASSERT_IMPL(a_busy_rise, clk, arst_n, $rose(busy), $past(start))
	// Configuration is refused while solving.
	`ASSERT_IMPL(a_cfg_blocked, clk, arst_n, busy, !cfg_ready)

endmodule

bind matrix_chain_order_cost mcoc_checker u_mcoc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cfg_ready (cfg_ready),
	.done      (done)
);
